>>> sv/hep_pkg.sv
// ----------------------------------------------------------------------------
// hep_pkg
// Shared types, constants and fixed-point helpers for the Heston Euler step.
// ----------------------------------------------------------------------------
package hep_pkg;

  // Payload and register widths
  localparam int unsigned NormW   = 16;
  localparam int unsigned ResW    = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 32;
  localparam int unsigned StepW   = 25;
  localparam int unsigned UPriceW = 31;
  localparam int unsigned CorrW   = 26;

  // Serial multiplier operand magnitude width
  localparam int unsigned MagW    = 62;

  // Register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_STEP   = 3'd0,
    REG_SPRICE = 3'd1,
    REG_SVAR   = 3'd2,
    REG_DRIFT  = 3'd3,
    REG_KAPPA  = 3'd4,
    REG_THETA  = 3'd5,
    REG_SIGMA  = 3'd6,
    REG_RHO    = 3'd7
  } cfg_reg_e;

  // Register reset values
  localparam logic [StepW-1:0]   RstStep  = 25'd65536;
  localparam logic [UPriceW-1:0] RstPrice = 31'd6553600;
  localparam logic [UPriceW-1:0] RstVar   = 31'd2621;
  localparam logic [31:0]        RstDrift = 32'd0;
  localparam logic [UPriceW-1:0] RstKappa = 31'd16777216;
  localparam logic [UPriceW-1:0] RstTheta = 31'd671088;
  localparam logic [UPriceW-1:0] RstSigma = 31'd5033165;
  localparam logic [CorrW-1:0]   RstRho   = 26'd0;

  localparam logic signed [63:0] OneQ24 = 64'sd16777216;
  localparam logic signed [63:0] Lim    = 64'sd1152921504606846976;

  // Sequencer steps
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RR,   // rho * rho
    ST_SQ,   // sqrt(1 - rho^2)
    ST_RW,   // rho * w
    ST_SN,   // sq * n2
    ST_SV,   // sqrt(V+)
    ST_SDT,  // sqrt(dt)
    ST_DM,   // mu * p
    ST_DS,   // * dt
    ST_PS,   // p * sqrt(dt)
    ST_PW,   // * w
    ST_PV,   // * sqrt(V+)
    ST_KT,   // kappa * (theta - V+)
    ST_KS,   // * dt
    ST_GS,   // sigma * sqrt(V+)
    ST_GT,   // * sqrt(dt)
    ST_GZ,   // * z
    ST_OUT
  } seq_state_e;

  // Clamp to +-2^60
  function automatic logic signed [63:0] sat60(input logic signed [63:0] x);
    logic signed [63:0] r;
    r = x;
    if (x > Lim) r = Lim;
    if (x < -Lim) r = -Lim;
    return r;
  endfunction

  // Q.24 to Q16.16, truncate toward zero, saturate to 32 bits
  function automatic logic signed [31:0] to_q16(input logic signed [63:0] x);
    logic [63:0] mag;
    logic [55:0] m;
    logic signed [31:0] r;
    mag = x[63] ? 64'(-x) : 64'(x);
    m = mag[63:8];
    if (!x[63]) begin
      r = (m > 56'd2147483647) ? 32'sh7fffffff : signed'(m[31:0]);
    end else begin
      r = (m > 56'd2147483648) ? 32'sh80000000 : signed'(32'(-m[31:0]));
    end
    return r;
  endfunction

endpackage

>>> sv/hep_in_if.sv
// ----------------------------------------------------------------------------
// hep_in_if
// Input channel: path restart flag and two normal samples.
// ----------------------------------------------------------------------------
interface hep_in_if
  import hep_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic                    path_start;
  logic signed [NormW-1:0] normal_first;
  logic signed [NormW-1:0] normal_second;

  modport source (output valid, path_start, normal_first, normal_second, input ready);
  modport sink   (input valid, path_start, normal_first, normal_second, output ready);
endinterface

>>> sv/hep_out_if.sv
// ----------------------------------------------------------------------------
// hep_out_if
// Output channel: price and variance after one step.
// ----------------------------------------------------------------------------
interface hep_out_if
  import hep_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic signed [ResW-1:0] step_price;
  logic signed [ResW-1:0] next_variance;

  modport source (output valid, step_price, next_variance, input ready);
  modport sink   (input valid, step_price, next_variance, output ready);
endinterface

>>> sv/hep_mul.sv
// ----------------------------------------------------------------------------
// hep_mul
// Bit-serial signed multiplier, Q.24 product truncated toward zero and
// saturated at +-2^60. One multiplier bit per cycle.
// ----------------------------------------------------------------------------
module hep_mul
  import hep_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] a_i,
  input  logic signed [63:0] b_i,
  output logic               done_o,
  output logic signed [63:0] res_o
);

  logic [MagW-1:0]   a_q;
  logic [MagW-1:0]   lo_q, lo_d;
  logic [MagW-1:0]   hi_q, hi_d;
  logic [5:0]        cnt_q;
  logic              neg_q;
  logic              busy_q, fin_q, done_q;
  logic signed [63:0] res_q;
  logic [63:0]       a_mag, b_mag;
  logic [MagW:0]     sum;
  logic [2*MagW-1:0] prod;
  logic [99:0]       shr;
  logic              over;
  logic [63:0]       mag;

  assign a_mag = a_i[63] ? 64'(-a_i) : 64'(a_i);
  assign b_mag = b_i[63] ? 64'(-b_i) : 64'(b_i);

  // shift-add step
  assign sum  = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);
  assign hi_d = sum[MagW:1];
  assign lo_d = {sum[0], lo_q[MagW-1:1]};

  // final scale and saturation
  assign prod = {hi_q, lo_q};
  assign shr  = prod[2*MagW-1:24];
  assign over = (|shr[99:61]) || (shr[60] && (|shr[59:0]));
  assign mag  = over ? 64'(Lim) : {3'b0, shr[60:0]};

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'(MagW - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        done_q <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_mag[MagW-1:0];
      lo_q  <= b_mag[MagW-1:0];
      hi_q  <= '0;
      neg_q <= a_i[63] ^ b_i[63];
    end else if (busy_q) begin
      hi_q <= hi_d;
      lo_q <= lo_d;
    end
    if (fin_q) begin
      res_q <= neg_q ? -signed'(mag) : signed'(mag);
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> sv/hep_sqrt.sv
// ----------------------------------------------------------------------------
// hep_sqrt
// Serial integer square root, floor of the root of a 64-bit operand.
// Two operand bits per cycle.
// ----------------------------------------------------------------------------
module hep_sqrt
  import hep_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] op_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] op_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [35:0] rem_t, trial;
  logic        ge;

  // one result bit per step
  assign rem_t = {rem_q, op_q[63:62]};
  assign trial = {2'b0, root_q, 2'b01};
  assign ge    = rem_t >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      op_q   <= op_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      op_q   <= {op_q[61:0], 2'b00};
      rem_q  <= ge ? 34'(rem_t - trial) : rem_t[33:0];
      root_q <= {root_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> sv/heston_euler_path_step.sv
// ----------------------------------------------------------------------------
// heston_euler_path_step
// One Euler step of a Heston model Monte Carlo path per item.
// ----------------------------------------------------------------------------
// Each item advances the path by one step with full truncation of the
// variance and returns the new Q16.16 price and variance. A sequencer runs
// thirteen products on one bit-serial multiplier and three roots on one
// serial square root unit. One item is in work at a time; a finished
// result waits in the output register while the next item is accepted.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_data_i; the user
// must do so only while the block is idle, which the block itself does not
// enforce.
module heston_euler_path_step
  import hep_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  hep_in_if.sink             in_chan,
  hep_out_if.source          out_chan
);

  // configuration
  logic [StepW-1:0]        step_q;
  logic [UPriceW-1:0]      sprice_q, svar_q, kappa_q, theta_q, sigma_q;
  logic signed [31:0]      drift_q;
  logic signed [CorrW-1:0] corr_q;

  // path state and work registers
  logic signed [31:0] price_q, variance_q;
  logic signed [27:0] w_q, n2_q;
  logic [31:0]        sq_q, sv_q, sdt_q;
  logic signed [63:0] z_q, tmp_q, accp_q, accv_q;
  logic               out_valid_q;
  logic signed [31:0] out_price_q, out_var_q;

  seq_state_e state_q, state_d;
  logic       launched_q, launched_d;
  logic       is_mul, is_sqrt;
  logic       mul_start, sqrt_start, mul_done, sqrt_done;
  logic signed [63:0] mul_a, mul_b, mul_res;
  logic [63:0]        sqrt_op;
  logic [31:0]        sqrt_root;
  logic               in_acc, out_load;

  logic signed [63:0] rho_s, p_s, v_s, w_s, n2_s, vp256, diff_s;
  logic [30:0]        vp;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= RstStep;
      sprice_q <= RstPrice;
      svar_q   <= RstVar;
      drift_q  <= signed'(RstDrift);
      kappa_q  <= RstKappa;
      theta_q  <= RstTheta;
      sigma_q  <= RstSigma;
      corr_q   <= signed'(RstRho);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_STEP:   step_q   <= cfg_data_i[StepW-1:0];
        REG_SPRICE: sprice_q <= cfg_data_i[UPriceW-1:0];
        REG_SVAR:   svar_q   <= cfg_data_i[UPriceW-1:0];
        REG_DRIFT:  drift_q  <= signed'(cfg_data_i);
        REG_KAPPA:  kappa_q  <= cfg_data_i[UPriceW-1:0];
        REG_THETA:  theta_q  <= cfg_data_i[UPriceW-1:0];
        REG_SIGMA:  sigma_q  <= cfg_data_i[UPriceW-1:0];
        REG_RHO:    corr_q   <= signed'(cfg_data_i[CorrW-1:0]);
        default: ;
      endcase
    end
  end

  // derived operands
  always_comb begin
    if (corr_q > 26'sd16777216) begin
      rho_s = OneQ24;
    end else if (corr_q < -26'sd16777216) begin
      rho_s = -OneQ24;
    end else begin
      rho_s = {{(64-CorrW){corr_q[CorrW-1]}}, corr_q};
    end
  end

  assign p_s    = {{24{price_q[31]}}, price_q, 8'b0};
  assign v_s    = {{24{variance_q[31]}}, variance_q, 8'b0};
  assign w_s    = {{36{w_q[27]}}, w_q};
  assign n2_s   = {{36{n2_q[27]}}, n2_q};
  assign vp     = variance_q[31] ? 31'd0 : variance_q[30:0];
  assign vp256  = {25'b0, vp, 8'b0};
  assign diff_s = {33'b0, theta_q} - vp256;

  assign in_acc   = in_chan.valid && in_chan.ready;
  assign out_load = (state_q == ST_OUT) && (!out_valid_q || out_chan.ready);

  // operand select
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    sqrt_op = '0;
    is_mul  = 1'b0;
    is_sqrt = 1'b0;
    unique case (state_q)
      ST_RR:  begin is_mul = 1'b1; mul_a = rho_s; mul_b = rho_s; end
      ST_SQ:  begin is_sqrt = 1'b1; sqrt_op = {15'b0, tmp_q[24:0], 24'b0}; end
      ST_RW:  begin is_mul = 1'b1; mul_a = rho_s; mul_b = w_s; end
      ST_SN:  begin is_mul = 1'b1; mul_a = {32'b0, sq_q}; mul_b = n2_s; end
      ST_SV:  begin is_sqrt = 1'b1; sqrt_op = {1'b0, vp, 32'b0}; end
      ST_SDT: begin is_sqrt = 1'b1; sqrt_op = {15'b0, step_q, 24'b0}; end
      ST_DM:  begin is_mul = 1'b1; mul_a = {{32{drift_q[31]}}, drift_q}; mul_b = p_s; end
      ST_DS:  begin is_mul = 1'b1; mul_a = tmp_q; mul_b = {39'b0, step_q}; end
      ST_PS:  begin is_mul = 1'b1; mul_a = p_s; mul_b = {32'b0, sdt_q}; end
      ST_PW:  begin is_mul = 1'b1; mul_a = tmp_q; mul_b = w_s; end
      ST_PV:  begin is_mul = 1'b1; mul_a = tmp_q; mul_b = {32'b0, sv_q}; end
      ST_KT:  begin is_mul = 1'b1; mul_a = {33'b0, kappa_q}; mul_b = diff_s; end
      ST_KS:  begin is_mul = 1'b1; mul_a = tmp_q; mul_b = {39'b0, step_q}; end
      ST_GS:  begin is_mul = 1'b1; mul_a = {33'b0, sigma_q}; mul_b = {32'b0, sv_q}; end
      ST_GT:  begin is_mul = 1'b1; mul_a = tmp_q; mul_b = {32'b0, sdt_q}; end
      ST_GZ:  begin is_mul = 1'b1; mul_a = tmp_q; mul_b = z_q; end
      default: ;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_d    = state_q;
    launched_d = launched_q;
    mul_start  = 1'b0;
    sqrt_start = 1'b0;
    if ((is_mul || is_sqrt) && !launched_q) begin
      mul_start  = is_mul;
      sqrt_start = is_sqrt;
      launched_d = 1'b1;
    end
    unique case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_RR;
      ST_OUT:  if (out_load) state_d = ST_IDLE;
      default: begin
        if ((is_mul && mul_done) || (is_sqrt && sqrt_done)) begin
          launched_d = 1'b0;
          state_d    = seq_state_e'(state_q + 5'd1);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launched_q  <= 1'b0;
      out_valid_q <= 1'b0;
      price_q     <= '0;
      variance_q  <= '0;
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
        price_q     <= to_q16(accp_q);
        variance_q  <= to_q16(accv_q);
      end else if (out_chan.ready) begin
        out_valid_q <= 1'b0;
      end
      // restart the path from the configured start point
      if (in_acc && in_chan.path_start) begin
        price_q    <= signed'({1'b0, sprice_q});
        variance_q <= signed'({1'b0, svar_q});
      end
    end
  end

  // work registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      w_q  <= {in_chan.normal_first, 12'b0};
      n2_q <= {in_chan.normal_second, 12'b0};
    end
    if (out_load) begin
      out_price_q <= to_q16(accp_q);
      out_var_q   <= to_q16(accv_q);
    end
    if (mul_done || sqrt_done) begin
      unique case (state_q) inside
        ST_RR:  tmp_q  <= (mul_res > OneQ24) ? 64'sd0 : OneQ24 - mul_res;
        ST_SQ:  sq_q   <= sqrt_root;
        ST_RW:  z_q    <= mul_res;
        ST_SN:  z_q    <= z_q + mul_res;
        ST_SV:  sv_q   <= sqrt_root;
        ST_SDT: sdt_q  <= sqrt_root;
        ST_DS:  accp_q <= p_s + mul_res;
        ST_PV:  accp_q <= sat60(accp_q + mul_res);
        ST_KS:  accv_q <= v_s + mul_res;
        ST_GZ:  accv_q <= sat60(accv_q + mul_res);
        ST_DM, ST_PS, ST_PW, ST_KT, ST_GS, ST_GT: tmp_q <= mul_res;
        default: ;
      endcase
    end
  end

  hep_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .res_o   (mul_res)
  );

  hep_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .op_i    (sqrt_op),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  assign in_chan.ready          = (state_q == ST_IDLE);
  assign out_chan.valid         = out_valid_q;
  assign out_chan.step_price    = out_price_q;
  assign out_chan.next_variance = out_var_q;

endmodule
